FILE: design/lmfb_pkg.sv
package lmfb_pkg;

	localparam int LMFB_QUEUE_DEPTH = 2;
	localparam int LMFB_ROWS        = 8;

	localparam logic [15:0] LMFB_REG_ENABLE    = 16'h0C00;
	localparam logic [15:0] LMFB_REG_TEST      = 16'h0F00;
	localparam logic [15:0] LMFB_REG_INTENSITY = 16'h0A00;
	localparam logic [15:0] LMFB_REG_SCANLIM   = 16'h0B00;
	localparam logic [15:0] LMFB_REG_DECODE    = 16'h0900;
	localparam logic [7:0]  LMFB_MAX_INTENSITY = 8'h0F;
	localparam logic [7:0]  LMFB_MAX_SCANLIM   = 8'h07;
	localparam logic [7:0]  LMFB_LEFT_BIT      = 8'b1000_0000;
	localparam logic [7:0]  LMFB_INIT_INTENSITY = 8'h03;
	localparam logic [3:0]  LMFB_MAX_SPRITE    = 4'd8;
	localparam logic [2:0]  LMFB_INIT_LAST     = 3'd4;

	typedef enum logic [2:0] {
		CMD_SET_PIXEL = 3'd0,
		CMD_GET_PIXEL = 3'd1,
		CMD_COLUMN    = 3'd2,
		CMD_SPRITE    = 3'd3,
		CMD_CLEAR     = 3'd4,
		CMD_FLUSH     = 3'd5,
		CMD_CONTROL   = 3'd6,
		CMD_INIT      = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		SEL_ENABLE    = 2'd0,
		SEL_INTENSITY = 2'd1,
		SEL_DECODE    = 2'd2,
		SEL_SCANLIM   = 2'd3
	} reg_sel_t;

	typedef enum logic {
		KIND_FRAME  = 1'b0,
		KIND_ANSWER = 1'b1
	} kind_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

	// classified command as held in the queue
	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  x;
		logic [7:0]  y;
		logic        x_in;
		logic        y_in;
		logic        pixel_on;
		logic [7:0]  data_byte;
		logic [63:0] sprite_rows;
		logic [3:0]  spr_w;
		logic [3:0]  spr_h;
		logic [15:0] ctrl_word;
	} op_t;

	typedef struct packed {
		op_t  op;
		logic empty;
	} queue_head_t;

	function automatic logic [15:0] init_word(input logic [2:0] step);
		logic [15:0] w;
		w = LMFB_REG_ENABLE;
		case (step)
			3'd0:    w = LMFB_REG_ENABLE;
			3'd1:    w = LMFB_REG_INTENSITY | {8'h00, LMFB_INIT_INTENSITY};
			3'd2:    w = LMFB_REG_TEST;
			3'd3:    w = LMFB_REG_DECODE;
			3'd4:    w = LMFB_REG_SCANLIM | {8'h00, LMFB_MAX_SCANLIM};
			default: w = LMFB_REG_ENABLE;
		endcase
		return w;
	endfunction

endpackage

FILE: design/lmfb_if.sv
interface lmfb_req_if;
	logic              valid;
	logic              ready;
	logic [2:0]        cmd;
	logic signed [7:0] x;
	logic signed [7:0] y;
	logic              pixel_on;
	logic [7:0]        data_byte;
	logic [63:0]       sprite_rows;
	logic [3:0]        sprite_width;
	logic [3:0]        sprite_height;
	logic [1:0]        reg_select;

	modport source (
		output valid, cmd, x, y, pixel_on, data_byte, sprite_rows,
		       sprite_width, sprite_height, reg_select,
		input  ready
	);
	modport sink (
		input  valid, cmd, x, y, pixel_on, data_byte, sprite_rows,
		       sprite_width, sprite_height, reg_select,
		output ready
	);
endinterface

interface lmfb_rsp_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] spi_word;
	logic        pixel_value;
	logic        last;

	modport source (output valid, kind, spi_word, pixel_value, last, input ready);
	modport sink (input valid, kind, spi_word, pixel_value, last, output ready);
endinterface

FILE: design/lmfb_front.sv
module lmfb_front (
	lmfb_req_if.sink   req,
	input  logic       q_full,
	output logic       q_push,
	output lmfb_pkg::op_t q_op
);
	import lmfb_pkg::*;

	logic [7:0] val;

	assign val = req.data_byte;
	assign req.ready = !q_full;
	assign q_push = req.valid && !q_full;

	always_comb begin
		q_op = '0;
		q_op.cmd         = cmd_t'(req.cmd);
		q_op.x           = req.x;
		q_op.y           = req.y;
		// on screen when the upper five bits are all clear
		q_op.x_in        = (req.x[7:3] == 5'd0);
		q_op.y_in        = (req.y[7:3] == 5'd0);
		q_op.pixel_on    = req.pixel_on;
		q_op.data_byte   = val;
		q_op.sprite_rows = req.sprite_rows;
		q_op.spr_w = (req.sprite_width > LMFB_MAX_SPRITE) ? LMFB_MAX_SPRITE : req.sprite_width;
		q_op.spr_h = (req.sprite_height > LMFB_MAX_SPRITE) ? LMFB_MAX_SPRITE : req.sprite_height;
		unique case (reg_sel_t'(req.reg_select))
			SEL_ENABLE:    q_op.ctrl_word = LMFB_REG_ENABLE | {15'd0, (val != 8'd0)};
			SEL_INTENSITY: q_op.ctrl_word = LMFB_REG_INTENSITY |
				{8'h00, (val > LMFB_MAX_INTENSITY) ? LMFB_MAX_INTENSITY : val};
			SEL_DECODE:    q_op.ctrl_word = LMFB_REG_DECODE | {8'h00, val};
			SEL_SCANLIM:   q_op.ctrl_word = LMFB_REG_SCANLIM |
				{8'h00, (val > LMFB_MAX_SCANLIM) ? LMFB_MAX_SCANLIM : val};
			default:       q_op.ctrl_word = LMFB_REG_DECODE | {8'h00, val};
		endcase
	end
endmodule

FILE: design/lmfb_queue.sv
module lmfb_queue #(
	parameter int DEPTH = lmfb_pkg::LMFB_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lmfb_pkg::op_t       push_op,
	output logic                full,
	input  logic                pop,
	output lmfb_pkg::queue_head_t head
);
	import lmfb_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	op_t              mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.empty = (count_q == '0);
	assign head.op    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

FILE: design/lmfb_back.sv
module lmfb_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lmfb_pkg::queue_head_t head,
	output logic                  pop,
	lmfb_rsp_if.source            rsp
);
	import lmfb_pkg::*;

	back_state_t state_q, state_d;
	op_t         op_q;
	logic [2:0]  row_q;
	logic [7:0]  frame_q [LMFB_ROWS];

	logic        out_valid_q;
	logic        kind_q;
	logic [15:0] word_q;
	logic        pix_q;
	logic        last_q;

	logic        running;
	logic        emit_now;
	logic        advance;
	logic        final_step;
	logic [7:0]  cur_row;
	logic [7:0]  new_row;
	logic        e_kind;
	logic [15:0] e_word;
	logic        e_pix;
	logic        e_last;
	logic [2:0]  get_row;
	logic [7:0]  bit_mask;
	logic [8:0]  dr;
	logic        row_hit;
	logic [7:0]  srow;

	assign cur_row  = frame_q[row_q];
	assign bit_mask = LMFB_LEFT_BIT >> op_q.x[2:0];
	assign get_row  = op_q.y_in ? op_q.y[2:0] : 3'd0;

	// sprite row that lands on the current frame row
	assign dr      = {6'd0, row_q} - {op_q.y[7], op_q.y};
	assign row_hit = !dr[8] && (dr < {5'd0, op_q.spr_h});
	assign srow    = op_q.sprite_rows[{dr[2:0], 3'b000} +: 8];

	// emit decode for the current row step
	always_comb begin
		emit_now = 1'b0;
		e_kind   = KIND_FRAME;
		e_word   = 16'd0;
		e_pix    = 1'b0;
		e_last   = 1'b0;
		unique case (op_q.cmd)
			CMD_GET_PIXEL: begin
				emit_now = (row_q == get_row);
				e_kind   = KIND_ANSWER;
				e_pix    = op_q.x_in && op_q.y_in && cur_row[3'd7 - op_q.x[2:0]];
				e_last   = 1'b1;
			end
			CMD_FLUSH: begin
				emit_now = 1'b1;
				e_word   = {{5'd0, row_q} + 8'd1, cur_row};
				e_last   = (row_q == 3'd7);
			end
			CMD_CONTROL: begin
				emit_now = (row_q == 3'd0);
				e_word   = op_q.ctrl_word;
				e_last   = 1'b1;
			end
			CMD_INIT: begin
				emit_now = (row_q <= LMFB_INIT_LAST);
				e_word   = init_word(row_q);
				e_last   = (row_q == LMFB_INIT_LAST);
			end
			default: emit_now = 1'b0;
		endcase
	end

	// new contents of the current row
	always_comb begin
		logic [8:0] c;
		new_row = cur_row;
		c = 9'd0;
		unique case (op_q.cmd)
			CMD_SET_PIXEL: begin
				if (op_q.x_in && op_q.y_in && (row_q == op_q.y[2:0])) begin
					new_row = op_q.pixel_on ? (cur_row | bit_mask) : (cur_row & ~bit_mask);
				end
			end
			CMD_COLUMN: begin
				if (op_q.x_in) begin
					new_row = op_q.data_byte[row_q] ? (cur_row | bit_mask)
					                                : (cur_row & ~bit_mask);
				end
			end
			CMD_SPRITE: begin
				for (int j = 0; j < 8; j++) begin
					c = 9'(j) - {op_q.x[7], op_q.x};
					if (row_hit && !c[8] && (c[7:0] < {4'd0, op_q.spr_w})) begin
						new_row[7 - j] = srow[3'd7 - c[2:0]];
					end
				end
			end
			CMD_CLEAR, CMD_INIT: new_row = 8'd0;
			default: new_row = cur_row;
		endcase
	end

	// sequencer outputs
	always_comb begin
		running    = (state_q == BK_RUN);
		advance    = running && (!emit_now || !out_valid_q || rsp.ready);
		final_step = advance && (row_q == 3'd7);
		pop        = !head.empty && ((state_q == BK_IDLE) || final_step);
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (!head.empty) state_d = BK_RUN;
			BK_RUN:  if (final_step && head.empty) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			row_q       <= 3'd0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < LMFB_ROWS; i++) begin
				frame_q[i] <= 8'd0;
			end
		end else begin
			state_q <= state_d;
			if (pop) begin
				row_q <= 3'd0;
			end else if (advance) begin
				row_q <= row_q + 3'd1;
			end
			if (advance) begin
				frame_q[row_q] <= new_row;
			end
			if (advance && emit_now) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= head.op;
		end
		if (advance && emit_now) begin
			kind_q <= e_kind;
			word_q <= e_word;
			pix_q  <= e_pix;
			last_q <= e_last;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.kind        = kind_q;
	assign rsp.spi_word    = word_q;
	assign rsp.pixel_value = pix_q;
	assign rsp.last        = last_q;
endmodule

FILE: design/led_matrix_framebuffer_spi_core.sv
// results: each command passes through the queue and the back end's op register, and
// its results are registered; flush frames follow one per cycle when not stalled
// occupancy: every command holds the back end while it steps through all frame rows,
// one row per step, since the store is read and rewritten through a single row port
// reset: arst_n clears the frame store, the command queue and the output register
module led_matrix_framebuffer_spi_core #(
	parameter int QUEUE_DEPTH = lmfb_pkg::LMFB_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	lmfb_req_if.sink   req,
	lmfb_rsp_if.source rsp
);
	import lmfb_pkg::*;

	logic        q_full;
	logic        q_push;
	logic        q_pop;
	op_t         q_op;
	queue_head_t q_head;

	lmfb_front u_front (
		.req    (req),
		.q_full (q_full),
		.q_push (q_push),
		.q_op   (q_op)
	);

	lmfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (q_op),
		.full    (q_full),
		.pop     (q_pop),
		.head    (q_head)
	);

	lmfb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.pop    (q_pop),
		.rsp    (rsp)
	);
endmodule

FILE: design/lmfb_checker.sv
module lmfb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_kind,
	input logic [15:0] out_word,
	input logic        out_pix,
	input logic        out_last
);
	import lmfb_pkg::*;

	// a stalled transfer keeps its frame
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
		else $error("output changed while stalled");

	a_answer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind |-> (out_word == 16'd0) && out_last)
		else $error("pixel answer malformed");

	a_frame_pix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_kind |-> !out_pix)
		else $error("pixel bit set on serial frame");

	// test register only appears inside init, never last
	a_test_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_kind && (out_word[15:8] == LMFB_REG_TEST[15:8])
		|-> (out_word[7:0] == 8'd0) && !out_last)
		else $error("test register frame malformed");

	// row eight closes a flush
	a_flush_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_kind && (out_word[15:8] == 8'd8) |-> out_last)
		else $error("last flush row not marked");
endmodule

bind led_matrix_framebuffer_spi_core lmfb_checker u_lmfb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_kind  (rsp.kind),
	.out_word  (rsp.spi_word),
	.out_pix   (rsp.pixel_value),
	.out_last  (rsp.last)
);
